// ===== hw/rtl/c8ie_pkg.sv =====
// Shared types and constants for the CHIP-8 instruction execute block.
package c8ie_pkg;
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_UNHANDLED = 2'd3;

    localparam logic [11:0] PC_RESET = 12'h200;

    typedef enum logic [3:0] {
        K_RET, K_JP, K_CALL, K_SE_K, K_SNE_K, K_SE_V, K_SNE_V, K_LD_K,
        K_ADD_K, K_ALU, K_LD_I, K_JP_V0, K_RND, K_UNH
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  n;
        logic [7:0]  kk;
        logic [11:0] nnn;
        logic [7:0]  rnd;
    } t_op;
endpackage

// ===== hw/rtl/c8ie_front.sv =====
// Front end: accepts instruction words, decodes them, and queues them.
module c8ie_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [15:0]    i_op,
    input  logic [7:0]     i_rnd,
    output logic           o_valid,
    input  logic           i_ready,
    output c8ie_pkg::t_op  o_op
);
    import c8ie_pkg::*;

    t_op        r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_op        n_op;
    logic       w_push, w_pop;

    always_comb begin
        n_op.x   = i_op[11:8];
        n_op.y   = i_op[7:4];
        n_op.n   = i_op[3:0];
        n_op.kk  = i_op[7:0];
        n_op.nnn = i_op[11:0];
        n_op.rnd = i_rnd;
        case (i_op[15:12])
            4'h0: n_op.kind = (i_op == 16'h00EE) ? K_RET : K_UNH;
            4'h1: n_op.kind = K_JP;
            4'h2: n_op.kind = K_CALL;
            4'h3: n_op.kind = K_SE_K;
            4'h4: n_op.kind = K_SNE_K;
            4'h5: n_op.kind = K_SE_V;
            4'h6: n_op.kind = K_LD_K;
            4'h7: n_op.kind = K_ADD_K;
            4'h8: n_op.kind = (i_op[3:0] <= 4'h7 || i_op[3:0] == 4'hE) ? K_ALU : K_UNH;
            4'h9: n_op.kind = K_SNE_V;
            4'hA: n_op.kind = K_LD_I;
            4'hB: n_op.kind = K_JP_V0;
            4'hC: n_op.kind = K_RND;
            default: n_op.kind = K_UNH;
        endcase
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= n_op;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// ===== hw/rtl/c8ie_back.sv =====
// Back end: executes decoded instructions against the architectural state.
module c8ie_back #(
    parameter int STACK_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [11:0]   i_cfg_pc,
    input  logic          i_valid,
    output logic          o_ready,
    input  c8ie_pkg::t_op i_op,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [47:0]   o_data
);
    import c8ie_pkg::*;
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic [7:0]  r_v [16];
    logic [11:0] r_stk [STACK_DEPTH];
    logic [11:0] r_i, r_pc;
    logic [DW-1:0] r_sp;
    logic        r_ov;
    logic [47:0] r_data;

    logic [7:0]  w_vx, w_vy, n_val;
    logic [8:0]  w_sum;
    logic [11:0] n_pc, n_i, w_pc2, w_pc4;
    logic        n_rw, n_fw, n_fv, w_go;
    logic [1:0]  n_st;
    logic [SW-1:0] w_top;

    assign w_vx  = r_v[i_op.x];
    assign w_vy  = r_v[i_op.y];
    assign w_pc2 = r_pc + 12'd2;
    assign w_pc4 = r_pc + 12'd4;
    assign w_top = SW'(r_sp - DW'(1));
    assign o_ready = !r_ov || i_ready;
    assign w_go  = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_data  = r_data;

    always_comb begin
        n_pc = w_pc2; n_i = r_i; n_rw = 1'b0; n_fw = 1'b0; n_fv = 1'b0;
        n_val = 8'd0; n_st = ST_OK; w_sum = 9'd0;
        case (i_op.kind)
            K_RET: if (r_sp == '0) begin
                n_pc = r_pc; n_st = ST_UNDERFLOW;
            end else begin
                n_pc = r_stk[w_top];
            end
            K_JP: n_pc = i_op.nnn;
            K_CALL: if (r_sp == DW'(STACK_DEPTH)) begin
                n_pc = r_pc; n_st = ST_OVERFLOW;
            end else begin
                n_pc = i_op.nnn;
            end
            K_SE_K:  if (w_vx == i_op.kk) n_pc = w_pc4;
            K_SNE_K: if (w_vx != i_op.kk) n_pc = w_pc4;
            K_SE_V:  if (w_vx == w_vy) n_pc = w_pc4;
            K_SNE_V: if (w_vx != w_vy) n_pc = w_pc4;
            K_LD_K: begin n_rw = 1'b1; n_val = i_op.kk; end
            K_ADD_K: begin n_rw = 1'b1; n_val = w_vx + i_op.kk; end
            K_RND: begin n_rw = 1'b1; n_val = i_op.rnd & i_op.kk; end
            K_LD_I: n_i = i_op.nnn;
            K_JP_V0: n_pc = i_op.nnn + {4'd0, r_v[0]};
            K_ALU: begin
                n_rw = 1'b1;
                case (i_op.n)
                    4'h0: n_val = w_vy;
                    4'h1: n_val = w_vx | w_vy;
                    4'h2: n_val = w_vx & w_vy;
                    4'h3: n_val = w_vx ^ w_vy;
                    4'h4: begin
                        w_sum = {1'b0, w_vx} + {1'b0, w_vy};
                        n_val = w_sum[7:0]; n_fw = 1'b1; n_fv = w_sum[8];
                    end
                    4'h5: begin n_val = w_vx - w_vy; n_fw = 1'b1; n_fv = w_vx >= w_vy; end
                    4'h6: begin n_val = w_vy >> 1; n_fw = 1'b1; n_fv = w_vy[0]; end
                    4'h7: begin n_val = w_vy - w_vx; n_fw = 1'b1; n_fv = w_vy >= w_vx; end
                    default: begin n_val = w_vy << 1; n_fw = 1'b1; n_fv = w_vy[7]; end
                endcase
            end
            default: n_st = ST_UNHANDLED;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_data <= {7'd0, n_st, n_i, n_fv, n_fw, n_val,
                       n_rw ? i_op.x : 4'd0, n_rw, n_pc};
            if (i_op.kind == K_CALL && r_sp != DW'(STACK_DEPTH))
                r_stk[SW'(r_sp)] <= w_pc2;
        end
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) r_v[k] <= 8'd0;
            r_i  <= 12'd0;
            r_pc <= PC_RESET;
            r_sp <= '0;
            r_ov <= 1'b0;
        end else begin
            if (w_go) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            if (i_cfg_we) begin
                r_pc <= i_cfg_pc;
            end else if (w_go) begin
                r_pc <= n_pc;
                r_i  <= n_i;
                if (n_rw) r_v[i_op.x] <= n_val;
                if (n_fw) r_v[15] <= {7'd0, n_fv};
                if (i_op.kind == K_CALL && n_st == ST_OK) r_sp <= r_sp + DW'(1);
                if (i_op.kind == K_RET && n_st == ST_OK) r_sp <= r_sp - DW'(1);
            end
        end
    end
endmodule

// ===== hw/rtl/chip8_instruction_execute.sv =====
// Top level: CHIP-8 instruction execute block, decode front and execute back.
// One instruction word per cycle is sustained while m_axis_tready stays high: the back
// end executes each word against the register file; a two-entry queue separates
// decode from execute, and a new word enters the result register only when it is
// empty or its result is taken. Each word is registered in the queue, then in the result register.
module chip8_instruction_execute #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [11:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // instruction_word, random_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // next_pc, reg_write, reg_number, reg_value,
                                       // flag_write, flag_value, index_value, status
);
    import c8ie_pkg::*;

    t_op  w_op;
    logic w_qv, w_qr;

    assign o_cfg_ready = 1'b1;

    c8ie_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(s_axis_tdata[15:0]), .i_rnd(s_axis_tdata[23:16]),
        .o_valid(w_qv), .i_ready(w_qr), .o_op(w_op)
    );

    c8ie_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .i_clk, .i_rst_n,
        .i_cfg_we(i_cfg_valid), .i_cfg_pc(i_cfg_data),
        .i_valid(w_qv), .o_ready(w_qr), .i_op(w_op),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(m_axis_tdata)
    );
endmodule

// ===== hw/rtl/c8ie_checker.sv =====
// Port-level assertions for the CHIP-8 instruction execute block.
module c8ie_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled word changed");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[47:41] == 7'd0)
        else $error("padding bits set");
    a_regnum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[12] |-> m_axis_tdata[16:13] == 4'd0
        && m_axis_tdata[24:17] == 8'd0)
        else $error("register fields set without write");
    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[25] |-> m_axis_tdata[12] && m_axis_tdata[40:39] == 2'd0)
        else $error("flag write without register write");
endmodule

bind chip8_instruction_execute c8ie_checker u_c8ie_checker (
    .i_clk, .i_rst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

// ===== dv/chip8_execute_checker.sv =====
// Checker for the CHIP-8 execute block: mirrors the machine state and compares each result word.
`timescale 1ns / 100ps
module chip8_execute_checker #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [11:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [23:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [47:0] i_out_data,
    output int          o_errors,
    output int          o_pending
);
    import c8ie_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] index_value;
        logic        flag_value;
        logic        flag_write;
        logic [7:0]  reg_value;
        logic [3:0]  reg_number;
        logic        reg_write;
        logic [11:0] next_pc;
    } t_outcome;

    logic [7:0]  vreg [16];
    logic [11:0] ireg;
    logic [11:0] pc;
    logic [11:0] ret_stack [STACK_DEPTH];
    int          depth;
    t_outcome    expected_q [$];

    assign o_pending = expected_q.size();

    task automatic report_mismatch(input string what, input logic [11:0] got,
                                   input logic [11:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
        o_errors++;
    endtask

    function automatic t_outcome execute_word(input logic [15:0] op, input logic [7:0] rnd);
        t_outcome    r;
        logic [3:0]  x, y, n;
        logic [7:0]  kk, vx, vy;
        logic [8:0]  sum;
        logic        rw, fw, fv;
        logic [7:0]  rv;
        logic [11:0] nxt;
        logic [1:0]  st;
        x = op[11:8]; y = op[7:4]; n = op[3:0]; kk = op[7:0];
        vx = vreg[x]; vy = vreg[y];
        nxt = pc + 12'd2; rw = 0; fw = 0; fv = 0; rv = 0; st = ST_OK;
        case (op[15:12])
            4'h0: begin
                if (op == 16'h00EE) begin
                    if (depth == 0) begin
                        nxt = pc; st = ST_UNDERFLOW;
                    end else begin
                        depth--; nxt = ret_stack[depth];
                    end
                end else st = ST_UNHANDLED;
            end
            4'h1: nxt = op[11:0];
            4'h2: begin
                if (depth >= STACK_DEPTH) begin
                    nxt = pc; st = ST_OVERFLOW;
                end else begin
                    ret_stack[depth] = pc + 12'd2; depth++; nxt = op[11:0];
                end
            end
            4'h3: if (vx == kk) nxt = pc + 12'd4;
            4'h4: if (vx != kk) nxt = pc + 12'd4;
            4'h5: if (vx == vy) nxt = pc + 12'd4;
            4'h6: begin rw = 1; rv = kk; end
            4'h7: begin rw = 1; rv = vx + kk; end
            4'h8: begin
                rw = 1;
                case (n)
                    4'h0: rv = vy;
                    4'h1: rv = vx | vy;
                    4'h2: rv = vx & vy;
                    4'h3: rv = vx ^ vy;
                    4'h4: begin sum = vx + vy; rv = sum[7:0]; fw = 1; fv = sum[8]; end
                    4'h5: begin rv = vx - vy; fw = 1; fv = vx >= vy; end
                    4'h6: begin rv = vy >> 1; fw = 1; fv = vy[0]; end
                    4'h7: begin rv = vy - vx; fw = 1; fv = vy >= vx; end
                    4'hE: begin rv = vy << 1; fw = 1; fv = vy[7]; end
                    default: begin rw = 0; st = ST_UNHANDLED; end
                endcase
            end
            4'h9: if (vx != vy) nxt = pc + 12'd4;
            4'hA: ireg = op[11:0];
            4'hB: nxt = op[11:0] + {4'd0, vreg[0]};
            4'hC: begin rw = 1; rv = rnd & kk; end
            default: st = ST_UNHANDLED;
        endcase
        if (rw) vreg[x] = rv;
        if (fw) vreg[15] = {7'd0, fv};
        pc = nxt;
        r.next_pc = nxt; r.reg_write = rw; r.reg_number = rw ? x : 4'd0;
        r.reg_value = rv; r.flag_write = fw; r.flag_value = fv;
        r.index_value = ireg; r.status = st;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_outcome got, want;
        if (!i_rst_n) begin
            foreach (vreg[k]) vreg[k] = 0;
            ireg = 0; pc = PC_RESET; depth = 0; o_errors = 0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) pc = i_cfg_data;
            if (i_in_valid && i_in_ready)
                expected_q.push_back(execute_word(i_in_data[15:0], i_in_data[23:16]));
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[$bits(t_outcome)-1:0];
                if (expected_q.size() == 0) begin
                    $display("MISMATCH unexpected word at %0t", $time);
                    o_errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.next_pc != want.next_pc)
                        report_mismatch("next_pc", got.next_pc, want.next_pc);
                    if (got.reg_write != want.reg_write)
                        report_mismatch("reg_write", got.reg_write, want.reg_write);
                    if (got.reg_number != want.reg_number)
                        report_mismatch("reg_number", got.reg_number, want.reg_number);
                    if (got.reg_value != want.reg_value)
                        report_mismatch("reg_value", got.reg_value, want.reg_value);
                    if (got.flag_write != want.flag_write)
                        report_mismatch("flag_write", got.flag_write, want.flag_write);
                    if (got.flag_value != want.flag_value)
                        report_mismatch("flag_value", got.flag_value, want.flag_value);
                    if (got.index_value != want.index_value)
                        report_mismatch("index_value", got.index_value, want.index_value);
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                end
            end
        end
    end
endmodule

// ===== dv/testbench.sv =====
// Testbench top: drives instruction words and start addresses into the execute block.
`timescale 1ns / 100ps
module testbench;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic [11:0] i_cfg_data = 0;
    logic        s_axis_tvalid = 0;
    logic [23:0] s_axis_tdata = 0;
    logic        m_axis_tready = 0;
    logic        o_cfg_ready, s_axis_tready, m_axis_tvalid;
    logic [47:0] m_axis_tdata;
    int          errors, pending;
    int          send_idle = 0, recv_idle = 0;
    int          quiet = 0;
    int          depth_model = 0;

    localparam int WATCHDOG = 20000;

    chip8_instruction_execute i_dut (.*);

    chip8_execute_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .o_errors(errors), .o_pending(pending)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_word(input logic [15:0] op, input logic [7:0] rnd);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {rnd, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic write_start(input logic [11:0] addr);
        s_axis_tvalid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_data <= addr;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
    endtask

    // Mostly valid-looking programs; call/return kept near a sane stack depth.
    function automatic logic [15:0] pick_word();
        logic [15:0] w;
        w = 16'($urandom);
        case ($urandom_range(19))
            0: w = 16'h00EE;
            1: w[15:12] = 4'h2;
            2: w = {4'h8, w[11:4], 4'h4};
            3: w = {4'h8, w[11:4], 4'h5};
            4: w = {4'h8, w[11:4], 4'h7};
            5: w = {4'h8, w[11:4], 4'hE};
            6: w = {4'h8, w[11:4], 4'h6};
            7, 8: w[15:12] = 4'h6;
            default: ;
        endcase
        return w;
    endfunction

    task automatic run_random(input int count);
        logic [15:0] w;
        repeat (count) begin
            w = pick_word();
            if (w[15:12] == 4'h2 && depth_model > 12 && $urandom_range(3) != 0)
                w = 16'h00EE;
            if (w == 16'h00EE && depth_model > 0) depth_model--;
            else if (w[15:12] == 4'h2 && depth_model < 16) depth_model++;
            send_word(w, 8'($urandom));
        end
    endtask

    initial begin
        logic [15:0] dir [$];
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        dir = '{16'h00EE, 16'h6AFF, 16'h6B01, 16'h8AB4, 16'h8AB5, 16'h8BA7, 16'h6C80,
                16'h8FC6, 16'h8FCE, 16'h8AC6, 16'h7AFF, 16'h3A00, 16'h4AFF, 16'h5AB0,
                16'h9AB1, 16'hAFFF, 16'hB0FF, 16'hC0FF, 16'h00E0, 16'h8AB8, 16'hD123,
                16'hE19E, 16'hF00F, 16'h1FFE, 16'h8AB0};
        foreach (dir[k]) send_word(dir[k], 8'hFF);
        for (int k = 0; k < 17; k++) send_word(16'h2FFF, 8'h00);
        for (int k = 0; k < 17; k++) send_word(16'h00EE, 8'h00);
        write_start(12'hFFF);
        send_word(16'h8123, 8'h5A);
        send_idle = 23; recv_idle = 73;
        run_random(270);
        write_start(12'h000);
        send_idle = 73; recv_idle = 23;
        run_random(270);
        write_start(12'($urandom));
        send_idle = 0; recv_idle = 0;
        run_random(270);
        s_axis_tvalid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/c8ie_pkg.sv
hw/rtl/c8ie_front.sv
hw/rtl/c8ie_back.sv
hw/rtl/chip8_instruction_execute.sv
hw/rtl/c8ie_checker.sv
dv/chip8_execute_checker.sv
dv/testbench.sv
